/* rtl/lspm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspm_pkg: shared types and constants of the looping sample player
// Action and register codes, reset values, controller states and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package lspm_pkg;

    localparam int SAMPLE_ADDR_BITS_DEF = 12;

    localparam int LEN_W     = 13;
    localparam int SPEED_W   = 24;
    localparam int GAIN_W    = 16;
    localparam int PAN_W     = 17;
    localparam int SAMPLE_W  = 16;
    localparam int MIX_W     = 24;
    localparam int ADDR_IN_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int FRAC_W    = 16;

    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;
    localparam logic [1:0] ACT_LOAD  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN    = 3'd4;

    localparam logic [LEN_W-1:0]   RST_LENGTH = 13'd0;
    localparam logic [SPEED_W-1:0] RST_SPEED  = 24'd65536;
    localparam logic [GAIN_W-1:0]  RST_AMP    = 16'd16384;
    localparam logic [GAIN_W-1:0]  RST_VOLUME = 16'd16384;
    localparam logic [PAN_W-1:0]   RST_PAN    = 17'd32768;

    localparam logic [PAN_W-1:0] PAN_ONE = 17'h10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_POS_WAIT,
        ST_READ,
        ST_M_AMP,
        ST_M_VOL,
        ST_M_LLO,
        ST_M_LHI,
        ST_M_RLO,
        ST_M_RHI,
        ST_M_SUMR,
        ST_WRAP,
        ST_WRAP_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_AMP,
        MUL_VOL,
        MUL_LLO,
        MUL_LHI,
        MUL_RLO,
        MUL_RHI,
        MUL_SUMR
    } t_mul;

    typedef struct packed {
        logic cap;
        logic mod_start;
        logic mod_wrap;
        logic ram_rd;
        logic adv;
        logic wrap_keep;
        t_mul mul_op;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic mod_done;
        logic wrap_need;
        logic out_free;
    } t_sts;

endpackage

/* rtl/looping_sample_player_mixer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_sample_player_mixer_top: looping sample player with stereo mix
// Sample RAM, play flag and Q.16 phase; each word loads, starts, stops or
// mixes one frame of the playing sample into the stereo bus.
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_ready   action, load addr/value, mix in
//   output   out        o_out_valid / i_out_ready mix out left/right, sounding
//   config   in         i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// Load, start, stop and frames while stopped go straight to write-back. A
// playing frame reduces the phase in the bit-serial remainder unit (W-bit
// integer phase, W = max(SAMPLE_ADDR_BITS,8)+1), runs the seven-step shared
// multiplier, then wraps the phase if needed. One word is in work at a time.
// Reset clears state only, no RAM pass. A stalled output holds the block in
// its last step; the next word is taken once the result moves to the output.
// ----------------------------------------------------------------------------
module looping_sample_player_mixer_top #(
    parameter int SAMPLE_ADDR_BITS = lspm_pkg::SAMPLE_ADDR_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [lspm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lspm_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_action,
    input  logic [lspm_pkg::ADDR_IN_W-1:0]        i_load_address,
    input  logic signed [lspm_pkg::SAMPLE_W-1:0]  i_load_value,
    input  logic signed [lspm_pkg::MIX_W-1:0]     i_mix_in_left,
    input  logic signed [lspm_pkg::MIX_W-1:0]     i_mix_in_right,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [lspm_pkg::MIX_W-1:0]     o_mix_out_left,
    output logic signed [lspm_pkg::MIX_W-1:0]     o_mix_out_right,
    output logic                                  o_sounding
);

    lspm_pkg::t_cmd cmd;
    lspm_pkg::t_sts sts;

    lspm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lspm_dp #(
        .SAMPLE_ADDR_BITS(SAMPLE_ADDR_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_load_address  (i_load_address),
        .i_load_value    (i_load_value),
        .i_mix_in_left   (i_mix_in_left),
        .i_mix_in_right  (i_mix_in_right),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_mix_out_left  (o_mix_out_left),
        .o_mix_out_right (o_mix_out_right),
        .o_sounding      (o_sounding),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

/* rtl/lspm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspm_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lspm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/lspm_mod.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspm_mod: bit-serial remainder unit
// Computes x mod len, one quotient bit per cycle; when x is already below
// len it skips the division and raises done in the cycle after start.
// ----------------------------------------------------------------------------
module lspm_mod #(
    parameter int SAMPLE_ADDR_BITS = lspm_pkg::SAMPLE_ADDR_BITS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic [((SAMPLE_ADDR_BITS > 8) ? SAMPLE_ADDR_BITS : 8):0] i_x,
    input  logic [SAMPLE_ADDR_BITS:0]                     i_len,
    output logic                                          o_done,
    output logic [SAMPLE_ADDR_BITS-1:0]                   o_rem
);

    localparam int LW   = SAMPLE_ADDR_BITS + 1;
    localparam int WI   = ((SAMPLE_ADDR_BITS > 8) ? SAMPLE_ADDR_BITS : 8) + 1;
    localparam int CNTW = $clog2(WI + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [WI-1:0]   r_x;
    logic [LW-1:0]   r_rem;

    logic [LW:0]   trial;
    logic [LW:0]   diff;
    logic [LW-1:0] n_rem;
    logic          early;

    assign early = i_x < WI'(i_len);
    assign trial = {r_rem, r_x[WI-1]};
    assign diff  = trial - {1'b0, i_len};
    assign n_rem = (trial >= {1'b0, i_len}) ? diff[LW-1:0] : trial[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (early) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNTW'(WI);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_rem <= early ? i_x[LW-1:0] : '0;
        end else if (r_busy) begin
            r_x   <= r_x << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[SAMPLE_ADDR_BITS-1:0];

endmodule

/* rtl/lspm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspm_dp: sample player datapath
// Config registers, play state, sample RAM, shared multiplier, remainder
// unit, rounding and saturating mix, output register.
// ----------------------------------------------------------------------------
module lspm_dp #(
    parameter int SAMPLE_ADDR_BITS = lspm_pkg::SAMPLE_ADDR_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [lspm_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lspm_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    input  logic [1:0]                            i_action,
    input  logic [lspm_pkg::ADDR_IN_W-1:0]        i_load_address,
    input  logic signed [lspm_pkg::SAMPLE_W-1:0]  i_load_value,
    input  logic signed [lspm_pkg::MIX_W-1:0]     i_mix_in_left,
    input  logic signed [lspm_pkg::MIX_W-1:0]     i_mix_in_right,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [lspm_pkg::MIX_W-1:0]     o_mix_out_left,
    output logic signed [lspm_pkg::MIX_W-1:0]     o_mix_out_right,
    output logic                                  o_sounding,
    input  lspm_pkg::t_cmd                        i_cmd,
    output lspm_pkg::t_sts                        o_sts
);

    localparam int A     = SAMPLE_ADDR_BITS;
    localparam int DEPTH = 1 << A;
    localparam int PW    = A + lspm_pkg::FRAC_W;
    localparam int LW    = A + 1;
    localparam int WI    = ((A > 8) ? A : 8) + 1;
    localparam int AW    = WI + lspm_pkg::FRAC_W;

    // config and play state
    logic [lspm_pkg::LEN_W-1:0]   r_len;
    logic [lspm_pkg::SPEED_W-1:0] r_speed;
    logic [lspm_pkg::GAIN_W-1:0]  r_amp;
    logic [lspm_pkg::GAIN_W-1:0]  r_vol;
    logic [lspm_pkg::PAN_W-1:0]   r_pan;
    logic                         r_playing;
    logic [PW-1:0]                r_phase;
    logic                         r_out_valid;
    logic                         r_go;

    // captured word and working registers
    logic [1:0]        r_action;
    logic [A-1:0]      r_addr;
    logic [15:0]       r_value;
    logic [23:0]       r_mixl;
    logic [23:0]       r_mixr;
    logic [A-1:0]      r_pos;
    logic [AW-1:0]     r_adv;
    logic [PW-1:0]     r_nphase;
    logic              r_mod_sel;
    logic [48:0]       r_prod;
    logic [46:0]       r_p2;
    logic [40:0]       r_lo;
    logic [63:0]       r_accl;
    logic [63:0]       r_accr;
    logic              r_neg;
    logic [23:0]       r_outl;
    logic [23:0]       r_outr;
    logic              r_sounding;

    logic [31:0]   len_ext;
    logic [31:0]   depth_ext;
    logic [31:0]   eff_len_ext;
    logic [LW-1:0] eff_len;
    logic [AW-1:0] span;
    logic [31:0]   addr_ext;
    logic          go_now;
    logic [16:0]   pan_sat;
    logic [16:0]   fac_l;
    logic [16:0]   fac_r;
    logic [15:0]   smp;
    logic          smp_neg;
    logic [15:0]   smp_mag;
    logic [31:0]   mul_a;
    logic [16:0]   mul_b;
    logic [48:0]   n_prod;
    logic [WI-1:0] mod_x;
    logic          mod_done;
    logic [A-1:0]  mod_rem;
    logic          out_free;
    logic          n_playing;
    logic [PW-1:0] n_phase;
    logic [23:0]   n_outl;
    logic [23:0]   n_outr;

    function automatic logic [23:0] mix_round(input logic [63:0] acc, input logic neg,
                                              input logic [23:0] mix);
        logic [63:0]        sum;
        logic [27:0]        mag;
        logic signed [29:0] c;
        logic signed [29:0] t;
        sum = acc + 64'h0000_0008_0000_0000;
        mag = sum[63:36];
        c   = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        t   = c + $signed({{6{mix[23]}}, mix});
        if (t > 30'sd8388607) begin
            return 24'h7FFFFF;
        end else if (t < -30'sd8388608) begin
            return 24'h800000;
        end else begin
            return t[23:0];
        end
    endfunction

    assign len_ext     = 32'(r_len);
    assign depth_ext   = 32'(DEPTH);
    assign eff_len_ext = (len_ext > depth_ext) ? depth_ext : len_ext;
    assign eff_len     = eff_len_ext[LW-1:0];
    assign span        = AW'({eff_len, 16'h0000});
    assign addr_ext    = 32'(i_load_address);
    assign go_now      = (i_action == lspm_pkg::ACT_FRAME) && r_playing && (eff_len != '0);

    assign pan_sat = (r_pan > lspm_pkg::PAN_ONE) ? lspm_pkg::PAN_ONE : r_pan;
    assign fac_l   = lspm_pkg::PAN_ONE - pan_sat;
    assign fac_r   = pan_sat;

    assign smp_neg = smp[15];
    assign smp_mag = smp_neg ? 16'(~smp + 16'd1) : smp;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_op)
            lspm_pkg::MUL_AMP: begin
                mul_a = 32'(smp_mag);
                mul_b = {1'b0, r_amp};
            end
            lspm_pkg::MUL_VOL: begin
                mul_a = r_prod[31:0];
                mul_b = {1'b0, r_vol};
            end
            lspm_pkg::MUL_LLO: begin
                mul_a = 32'(r_prod[23:0]);
                mul_b = fac_l;
            end
            lspm_pkg::MUL_LHI: begin
                mul_a = 32'(r_p2[46:24]);
                mul_b = fac_l;
            end
            lspm_pkg::MUL_RLO: begin
                mul_a = 32'(r_p2[23:0]);
                mul_b = fac_r;
            end
            lspm_pkg::MUL_RHI: begin
                mul_a = 32'(r_p2[46:24]);
                mul_b = fac_r;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = 49'(mul_a) * 49'(mul_b);

    assign mod_x = i_cmd.mod_wrap ? r_adv[AW-1:16] : WI'(r_phase[PW-1:16]);

    lspm_mod #(
        .SAMPLE_ADDR_BITS(SAMPLE_ADDR_BITS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mod_start),
        .i_x     (mod_x),
        .i_len   (eff_len),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    lspm_ram #(
        .WIDTH(lspm_pkg::SAMPLE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.done && (r_action == lspm_pkg::ACT_LOAD)),
        .i_wr_addr (r_addr),
        .i_wr_data (r_value),
        .i_rd_en   (i_cmd.ram_rd),
        .i_rd_addr (r_pos),
        .o_rd_data (smp)
    );

    always_comb begin
        n_playing = r_playing;
        n_phase   = r_phase;
        n_outl    = r_mixl;
        n_outr    = r_mixr;
        case (r_action)
            lspm_pkg::ACT_START: begin
                if (eff_len != '0) begin
                    n_playing = 1'b1;
                    n_phase   = '0;
                end
            end
            lspm_pkg::ACT_STOP: begin
                n_playing = 1'b0;
            end
            lspm_pkg::ACT_FRAME: begin
                if (r_go) begin
                    n_phase = r_nphase;
                    n_outl  = mix_round(r_accl, r_neg, r_mixl);
                    n_outr  = mix_round(r_accr, r_neg, r_mixr);
                end
            end
            default: begin
            end
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= lspm_pkg::RST_LENGTH;
            r_speed     <= lspm_pkg::RST_SPEED;
            r_amp       <= lspm_pkg::RST_AMP;
            r_vol       <= lspm_pkg::RST_VOLUME;
            r_pan       <= lspm_pkg::RST_PAN;
            r_playing   <= 1'b0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            r_go        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    lspm_pkg::CFG_LENGTH: r_len   <= i_cfg_data[12:0];
                    lspm_pkg::CFG_SPEED:  r_speed <= i_cfg_data;
                    lspm_pkg::CFG_AMP:    r_amp   <= i_cfg_data[15:0];
                    lspm_pkg::CFG_VOLUME: r_vol   <= i_cfg_data[15:0];
                    lspm_pkg::CFG_PAN:    r_pan   <= i_cfg_data[16:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.cap) begin
                r_go <= go_now;
            end
            if (i_cmd.done) begin
                r_playing   <= n_playing;
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_action <= i_action;
            r_addr   <= addr_ext[A-1:0];
            r_value  <= i_load_value;
            r_mixl   <= i_mix_in_left;
            r_mixr   <= i_mix_in_right;
        end
        if (i_cmd.mod_start) begin
            r_mod_sel <= i_cmd.mod_wrap;
        end
        if (mod_done) begin
            if (r_mod_sel) begin
                r_nphase <= {mod_rem, r_adv[15:0]};
            end else begin
                r_pos <= mod_rem;
            end
        end
        if (i_cmd.wrap_keep) begin
            r_nphase <= r_adv[PW-1:0];
        end
        if (i_cmd.adv) begin
            r_adv <= AW'(r_phase) + AW'(r_speed);
        end
        if (i_cmd.mul_op != lspm_pkg::MUL_NONE) begin
            r_prod <= n_prod;
        end
        case (i_cmd.mul_op)
            lspm_pkg::MUL_AMP:  r_neg  <= smp_neg;
            lspm_pkg::MUL_LLO:  r_p2   <= r_prod[46:0];
            lspm_pkg::MUL_LHI:  r_lo   <= r_prod[40:0];
            lspm_pkg::MUL_RLO:  r_accl <= (64'(r_prod[39:0]) << 24) + 64'(r_lo);
            lspm_pkg::MUL_RHI:  r_lo   <= r_prod[40:0];
            lspm_pkg::MUL_SUMR: r_accr <= (64'(r_prod[39:0]) << 24) + 64'(r_lo);
            default: begin
            end
        endcase
        if (i_cmd.done) begin
            r_outl     <= n_outl;
            r_outr     <= n_outr;
            r_sounding <= n_playing;
        end
    end

    assign o_sts.go        = r_go;
    assign o_sts.mod_done  = mod_done;
    assign o_sts.wrap_need = r_adv >= span;
    assign o_sts.out_free  = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_mix_out_left  = r_outl;
    assign o_mix_out_right = r_outr;
    assign o_sounding      = r_sounding;

endmodule

/* rtl/lspm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspm_ctrl: sample player controller
// Sequences capture, index remainder, sample read, multiply steps, phase
// wrap and result write-back.
// ----------------------------------------------------------------------------
module lspm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lspm_pkg::t_sts i_sts,
    output lspm_pkg::t_cmd o_cmd
);

    lspm_pkg::t_state r_state;
    lspm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lspm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lspm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lspm_pkg::ST_POS;
                end
            end
            lspm_pkg::ST_POS: begin
                n_state = i_sts.go ? lspm_pkg::ST_POS_WAIT : lspm_pkg::ST_DONE;
            end
            lspm_pkg::ST_POS_WAIT: begin
                if (i_sts.mod_done) begin
                    n_state = lspm_pkg::ST_READ;
                end
            end
            lspm_pkg::ST_READ:   n_state = lspm_pkg::ST_M_AMP;
            lspm_pkg::ST_M_AMP:  n_state = lspm_pkg::ST_M_VOL;
            lspm_pkg::ST_M_VOL:  n_state = lspm_pkg::ST_M_LLO;
            lspm_pkg::ST_M_LLO:  n_state = lspm_pkg::ST_M_LHI;
            lspm_pkg::ST_M_LHI:  n_state = lspm_pkg::ST_M_RLO;
            lspm_pkg::ST_M_RLO:  n_state = lspm_pkg::ST_M_RHI;
            lspm_pkg::ST_M_RHI:  n_state = lspm_pkg::ST_M_SUMR;
            lspm_pkg::ST_M_SUMR: n_state = lspm_pkg::ST_WRAP;
            lspm_pkg::ST_WRAP: begin
                n_state = i_sts.wrap_need ? lspm_pkg::ST_WRAP_WAIT : lspm_pkg::ST_DONE;
            end
            lspm_pkg::ST_WRAP_WAIT: begin
                if (i_sts.mod_done) begin
                    n_state = lspm_pkg::ST_DONE;
                end
            end
            lspm_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = lspm_pkg::ST_IDLE;
                end
            end
            default: n_state = lspm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.cap       = 1'b0;
        o_cmd.mod_start = 1'b0;
        o_cmd.mod_wrap  = 1'b0;
        o_cmd.ram_rd    = 1'b0;
        o_cmd.adv       = 1'b0;
        o_cmd.wrap_keep = 1'b0;
        o_cmd.mul_op    = lspm_pkg::MUL_NONE;
        o_cmd.done      = 1'b0;
        case (r_state)
            lspm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.cap  = i_in_valid;
            end
            lspm_pkg::ST_POS: begin
                o_cmd.mod_start = i_sts.go;
            end
            lspm_pkg::ST_READ: begin
                o_cmd.ram_rd = 1'b1;
                o_cmd.adv    = 1'b1;
            end
            lspm_pkg::ST_M_AMP:  o_cmd.mul_op = lspm_pkg::MUL_AMP;
            lspm_pkg::ST_M_VOL:  o_cmd.mul_op = lspm_pkg::MUL_VOL;
            lspm_pkg::ST_M_LLO:  o_cmd.mul_op = lspm_pkg::MUL_LLO;
            lspm_pkg::ST_M_LHI:  o_cmd.mul_op = lspm_pkg::MUL_LHI;
            lspm_pkg::ST_M_RLO:  o_cmd.mul_op = lspm_pkg::MUL_RLO;
            lspm_pkg::ST_M_RHI:  o_cmd.mul_op = lspm_pkg::MUL_RHI;
            lspm_pkg::ST_M_SUMR: o_cmd.mul_op = lspm_pkg::MUL_SUMR;
            lspm_pkg::ST_WRAP: begin
                o_cmd.mod_start = i_sts.wrap_need;
                o_cmd.mod_wrap  = i_sts.wrap_need;
                o_cmd.wrap_keep = !i_sts.wrap_need;
            end
            lspm_pkg::ST_DONE: begin
                o_cmd.done = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

/* verif/lspm_mix_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspm_mix_checker: result predictor and comparator for the sample player
// Watches register writes and both word channels of the sample player. It
// keeps its own sample memory, play flag, phase and register copy. For every
// accepted input word it computes the mixed output word and queues it. Each
// output word is compared field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module lspm_mix_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lspm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lspm_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [1:0]                      i_action,
    input  logic [lspm_pkg::ADDR_IN_W-1:0]  i_load_address,
    input  logic [lspm_pkg::SAMPLE_W-1:0]   i_load_value,
    input  logic [lspm_pkg::MIX_W-1:0]      i_mix_in_left,
    input  logic [lspm_pkg::MIX_W-1:0]      i_mix_in_right,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [lspm_pkg::MIX_W-1:0]      i_mix_out_left,
    input  logic [lspm_pkg::MIX_W-1:0]      i_mix_out_right,
    input  logic                            i_sounding,
    output int                              o_mismatches,
    output int                              o_due_words
);
    import lspm_pkg::*;

    localparam int     DEPTH  = 1 << SAMPLE_ADDR_BITS_DEF;
    localparam longint MIX_HI = 8388607;
    localparam longint MIX_LO = -8388608;

    typedef struct packed {
        logic [MIX_W-1:0] left;
        logic [MIX_W-1:0] right;
        logic             sounding;
    } mix_word_t;

    mix_word_t           mix_due[$];
    logic [SAMPLE_W-1:0] sample_mem [DEPTH];
    logic                playing;
    logic [63:0]         phase;
    logic [LEN_W-1:0]    length_q;
    logic [SPEED_W-1:0]  speed_q;
    logic [GAIN_W-1:0]   amp_q;
    logic [GAIN_W-1:0]   volume_q;
    logic [PAN_W-1:0]    pan_q;
    int                  words_seen;

    initial begin
        o_mismatches = 0;
        o_due_words  = 0;
        words_seen   = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    // sample * amp * volume * factor, 59 fraction bits, rounded half away to Q1.23
    function automatic longint scaled(input logic [SAMPLE_W-1:0] s,
                                      input logic [PAN_W-1:0] f);
        logic [63:0] mag;
        longint      sx;
        sx  = $signed(s);
        mag = (sx < 0) ? -sx : sx;
        mag = mag * amp_q * volume_q * f;
        mag = (mag + (64'd1 << 35)) >> 36;
        return (sx < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [MIX_W-1:0] mix_clip(input longint a, input longint b);
        longint r;
        r = a + b;
        if (r > MIX_HI) r = MIX_HI;
        if (r < MIX_LO) r = MIX_LO;
        return r[MIX_W-1:0];
    endfunction

    task automatic mix_one_word(input logic [1:0] act,
                                input logic [ADDR_IN_W-1:0] addr,
                                input logic [SAMPLE_W-1:0] value,
                                input logic [MIX_W-1:0] mix_l,
                                input logic [MIX_W-1:0] mix_r);
        mix_word_t        w;
        int unsigned      len;
        logic [63:0]      span;
        logic [63:0]      pos;
        logic [PAN_W-1:0] p;
        len = length_q;
        if (len > DEPTH) len = DEPTH;
        w.left  = mix_l;
        w.right = mix_r;
        case (act)
            ACT_START: begin
                if (len != 0) begin
                    playing = 1'b1;
                    phase   = '0;
                end
            end
            ACT_STOP: begin
                playing = 1'b0;
            end
            ACT_LOAD: begin
                sample_mem[addr] = value;
            end
            ACT_FRAME: begin
                if (playing && len != 0) begin
                    pos     = (phase >> FRAC_W) % len;
                    p       = (pan_q > PAN_ONE) ? PAN_ONE : pan_q;
                    w.left  = mix_clip($signed(mix_l), scaled(sample_mem[pos], PAN_ONE - p));
                    w.right = mix_clip($signed(mix_r), scaled(sample_mem[pos], p));
                    span    = len;
                    span    = span << FRAC_W;
                    phase   = phase + speed_q;
                    if (phase >= span) phase = phase % span;
                end
            end
        endcase
        w.sounding = playing;
        mix_due.push_back(w);
    endtask

    always @(posedge i_clk) begin : watch
        mix_word_t want;
        if (!i_rst_n) begin
            mix_due.delete();
            playing  = 1'b0;
            phase    = '0;
            length_q = RST_LENGTH;
            speed_q  = RST_SPEED;
            amp_q    = RST_AMP;
            volume_q = RST_VOLUME;
            pan_q    = RST_PAN;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_LENGTH: length_q = i_cfg_data[LEN_W-1:0];
                    CFG_SPEED:  speed_q  = i_cfg_data[SPEED_W-1:0];
                    CFG_AMP:    amp_q    = i_cfg_data[GAIN_W-1:0];
                    CFG_VOLUME: volume_q = i_cfg_data[GAIN_W-1:0];
                    CFG_PAN:    pan_q    = i_cfg_data[PAN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                mix_one_word(i_action, i_load_address, i_load_value,
                             i_mix_in_left, i_mix_in_right);
            end
            if (i_out_valid && i_out_ready) begin
                if (mix_due.size() == 0) begin
                    report_mismatch($sformatf("word %0d arrived with none due: L=%0d R=%0d",
                                              words_seen, $signed(i_mix_out_left),
                                              $signed(i_mix_out_right)));
                end else begin
                    want = mix_due.pop_front();
                    if (i_mix_out_left !== want.left)
                        report_mismatch($sformatf("word %0d left: got %0d, expected %0d",
                                                  words_seen, $signed(i_mix_out_left),
                                                  $signed(want.left)));
                    if (i_mix_out_right !== want.right)
                        report_mismatch($sformatf("word %0d right: got %0d, expected %0d",
                                                  words_seen, $signed(i_mix_out_right),
                                                  $signed(want.right)));
                    if (i_sounding !== want.sounding)
                        report_mismatch($sformatf("word %0d sounding: got %b, expected %b",
                                                  words_seen, i_sounding, want.sounding));
                end
                words_seen++;
            end
        end
        o_due_words = mix_due.size();
    end

endmodule

/* verif/tb_looping_sample_player_mixer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_looping_sample_player_mixer_top: testbench of the looping sample player
// Drives register writes and input words with random gaps, applies random
// output backpressure, and leaves prediction and comparison to the checker.
// A short directed run covers the edge cases, random phases with changing
// settings follow, then lengths at and above the memory depth are played
// over the loaded start of the sample memory.
// ----------------------------------------------------------------------------
module tb_looping_sample_player_mixer_top;
    import lspm_pkg::*;

    localparam int               DEPTH       = 1 << SAMPLE_ADDR_BITS_DEF;
    localparam int               STALL_LIMIT = 4000;
    localparam logic [MIX_W-1:0] MIX_TOP     = 24'h7FFFFF;
    localparam logic [MIX_W-1:0] MIX_BOTTOM  = 24'h800000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            action;
    logic [ADDR_IN_W-1:0]  load_address;
    logic [SAMPLE_W-1:0]   load_value;
    logic [MIX_W-1:0]      mix_in_left;
    logic [MIX_W-1:0]      mix_in_right;
    logic                  out_valid;
    logic                  out_ready;
    logic [MIX_W-1:0]      mix_out_left;
    logic [MIX_W-1:0]      mix_out_right;
    logic                  sounding;
    int                    mismatches;
    int                    due_words;

    bit                    written [DEPTH];
    int                    filled_prefix = 0;
    int                    sent_words = 0;
    int                    send_calm = 0;
    int                    take_calm = 0;

    looping_sample_player_mixer_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_action        (action),
        .i_load_address  (load_address),
        .i_load_value    (load_value),
        .i_mix_in_left   (mix_in_left),
        .i_mix_in_right  (mix_in_right),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_mix_out_left  (mix_out_left),
        .o_mix_out_right (mix_out_right),
        .o_sounding      (sounding)
    );

    lspm_mix_checker chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_action        (action),
        .i_load_address  (load_address),
        .i_load_value    (load_value),
        .i_mix_in_left   (mix_in_left),
        .i_mix_in_right  (mix_in_right),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_mix_out_left  (mix_out_left),
        .i_mix_out_right (mix_out_right),
        .i_sounding      (sounding),
        .o_mismatches    (mismatches),
        .o_due_words     (due_words)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // random idle gap before each word, with occasional stretches of back-to-back words
    task automatic pick_gap(inout int calm, output int gap);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 23) == 0) calm = $urandom_range(8, 40);
            gap = $urandom_range(0, 3);
        end
    endtask

    function automatic logic [MIX_W-1:0] any_mix();
        logic [31:0] r;
        r = $urandom;
        case (r[31:29])
            3'd0: return MIX_TOP;
            3'd1: return MIX_BOTTOM;
            3'd2: return {{12{r[23]}}, r[11:0]};
            default: return r[MIX_W-1:0];
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] any_gain();
        logic [31:0] r;
        r = $urandom;
        case (r[31:29])
            3'd0: return '0;
            3'd1: return '1;
            3'd2: return RST_AMP;
            default: return r[GAIN_W-1:0];
        endcase
    endfunction

    task automatic send_word(input logic [1:0] act,
                             input logic [ADDR_IN_W-1:0] addr,
                             input logic [SAMPLE_W-1:0] value,
                             input logic [MIX_W-1:0] mix_l,
                             input logic [MIX_W-1:0] mix_r);
        int gap;
        pick_gap(send_calm, gap);
        repeat (gap) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        action       = act;
        load_address = addr;
        load_value   = value;
        mix_in_left  = mix_l;
        mix_in_right = mix_r;
        in_valid     = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (act == ACT_LOAD) begin
            written[addr] = 1'b1;
            while (filled_prefix < DEPTH && written[filled_prefix]) filled_prefix++;
        end
        sent_words++;
    endtask

    task automatic hold_until_drained();
        in_valid = 1'b0;
        do @(negedge clk); while (due_words != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
    endtask

    task automatic program_player(input logic [LEN_W-1:0] len,
                                  input logic [SPEED_W-1:0] spd,
                                  input logic [GAIN_W-1:0] amp,
                                  input logic [GAIN_W-1:0] vol,
                                  input logic [PAN_W-1:0] pan);
        hold_until_drained();
        cfg_write(CFG_LENGTH, CFG_DAT_W'(len));
        cfg_write(CFG_SPEED, CFG_DAT_W'(spd));
        cfg_write(CFG_AMP, CFG_DAT_W'(amp));
        cfg_write(CFG_VOLUME, CFG_DAT_W'(vol));
        cfg_write(CFG_PAN, CFG_DAT_W'(pan));
        cfg_wr_en = 1'b0;
    endtask

    // lengths stay within the loaded prefix unless full is set
    task automatic pick_settings(input bit full);
        int unsigned        len_cap;
        int unsigned        len;
        logic [31:0]        r;
        logic [SPEED_W-1:0] spd;
        logic [PAN_W-1:0]   pan;
        len_cap = full ? 8191 : filled_prefix;
        case ($urandom_range(0, 5))
            0: len = 0;
            1: len = len_cap;
            2: len = full ? DEPTH : 1;
            3: len = full ? $urandom_range(DEPTH + 1, 8191) : $urandom_range(1, len_cap);
            default: len = $urandom_range(1, (len_cap < 16) ? len_cap : 16);
        endcase
        r = $urandom;
        case ($urandom_range(0, 5))
            0: spd = '0;
            1: spd = '1;
            2: spd = RST_SPEED;
            3: spd = r[SPEED_W-1:0];
            default: spd = SPEED_W'($urandom_range(0, 24'h03FFFF));
        endcase
        case ($urandom_range(0, 5))
            0: pan = '0;
            1: pan = PAN_ONE;
            2: pan = '1;
            3: pan = PAN_W'($urandom_range(32'(PAN_ONE) + 1, 17'h1FFFF));
            default: pan = PAN_W'($urandom_range(0, PAN_ONE));
        endcase
        program_player(len[LEN_W-1:0], spd, any_gain(), any_gain(), pan);
    endtask

    task automatic random_word();
        logic [31:0]          r;
        logic [31:0]          v;
        int                   pick;
        logic [ADDR_IN_W-1:0] addr;
        pick = $urandom_range(0, 99);
        r    = $urandom;
        v    = $urandom;
        addr = r[ADDR_IN_W-1:0];
        if (pick < 58) begin
            send_word(ACT_FRAME, addr, v[SAMPLE_W-1:0], any_mix(), any_mix());
        end else if (pick < 78) begin
            if (r[31] && filled_prefix < DEPTH) addr = filled_prefix[ADDR_IN_W-1:0];
            send_word(ACT_LOAD, addr, v[SAMPLE_W-1:0], any_mix(), any_mix());
        end else if (pick < 90) begin
            send_word(ACT_START, addr, v[SAMPLE_W-1:0], any_mix(), any_mix());
        end else begin
            send_word(ACT_STOP, addr, v[SAMPLE_W-1:0], any_mix(), any_mix());
        end
    endtask

    task automatic random_phase(input int count, input bit full);
        logic [31:0] r;
        pick_settings(full);
        r = $urandom;
        if (r[1:0] != 2'd0)
            send_word(ACT_START, r[ADDR_IN_W-1:0], r[31:16], any_mix(), any_mix());
        repeat (count) begin
            if ($urandom_range(0, 59) == 0) hold_until_drained();
            random_word();
        end
    endtask

    initial begin : take_side
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            pick_gap(take_calm, gap);
            repeat (gap) begin
                @(negedge clk);
                out_ready = 1'b0;
            end
            @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        action       = ACT_FRAME;
        load_address = '0;
        load_value   = '0;
        mix_in_left  = '0;
        mix_in_right = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stopped, no sample: pass-through, start ignored at zero length
        send_word(ACT_FRAME, '0, '0, MIX_TOP, MIX_BOTTOM);
        send_word(ACT_START, '0, '0, MIX_BOTTOM, MIX_TOP);
        send_word(ACT_STOP, '1, '1, '0, '1);
        send_word(ACT_LOAD, 12'd0, 16'h7FFF, '0, '0);
        send_word(ACT_LOAD, 12'd1, 16'h8000, '0, '0);
        send_word(ACT_LOAD, 12'd2, 16'h0000, '0, '0);
        send_word(ACT_LOAD, 12'd3, 16'hFFFF, '0, '0);
        send_word(ACT_LOAD, 12'hFFF, 16'hAAAA, MIX_TOP, MIX_TOP);

        // full gain, hard left: saturation both ways, wrap at length
        program_player(13'd4, RST_SPEED, '1, '1, '0);
        send_word(ACT_START, '0, '0, '0, '0);
        send_word(ACT_FRAME, '0, '0, MIX_TOP, MIX_TOP);
        send_word(ACT_FRAME, '0, '0, MIX_BOTTOM, MIX_BOTTOM);
        send_word(ACT_FRAME, '0, '0, '0, '0);
        send_word(ACT_FRAME, '0, '0, MIX_TOP, MIX_BOTTOM);
        send_word(ACT_FRAME, '0, '0, '0, '0);
        send_word(ACT_FRAME, '0, '0, '0, '0);

        // length shortened to the phase, hard right
        program_player(13'd2, RST_SPEED, '1, '1, PAN_ONE);
        send_word(ACT_FRAME, '0, '0, MIX_BOTTOM, MIX_TOP);
        send_word(ACT_FRAME, '0, '0, '0, '0);
        send_word(ACT_STOP, '0, '0, '0, '0);
        send_word(ACT_FRAME, '0, '0, MIX_TOP, MIX_TOP);

        // top speed, pan above one, zero gain, restart while playing
        program_player(13'd4, '1, '0, '1, '1);
        send_word(ACT_START, '0, '0, '0, '0);
        send_word(ACT_FRAME, '0, '0, MIX_TOP, MIX_BOTTOM);
        send_word(ACT_START, '0, '0, '0, '0);
        send_word(ACT_FRAME, '0, '0, '0, '0);

        while (sent_words < 1260) random_phase($urandom_range(20, 80), 1'b0);

        // length at and above the memory depth, frames stay in the loaded prefix
        program_player(13'(DEPTH), RST_SPEED, RST_AMP, RST_VOLUME, RST_PAN);
        send_word(ACT_START, '0, '0, any_mix(), any_mix());
        for (int i = 0; i < 12 && i < filled_prefix; i++)
            send_word(ACT_FRAME, '0, '0, any_mix(), any_mix());
        program_player(13'd8191, RST_SPEED, '1, '1, '1);
        send_word(ACT_START, '0, '0, any_mix(), any_mix());
        for (int i = 0; i < 12 && i < filled_prefix; i++)
            send_word(ACT_FRAME, '0, '0, any_mix(), any_mix());

        hold_until_drained();
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
rtl/lspm_pkg.sv
rtl/lspm_ram.sv
rtl/lspm_mod.sv
rtl/lspm_dp.sv
rtl/lspm_ctrl.sv
rtl/looping_sample_player_mixer_top.sv
verif/lspm_mix_checker.sv
verif/tb_looping_sample_player_mixer_top.sv
